@@ src/assert_macros.svh @@
// Assertion macros for the checker file tmseg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define TMSEG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tmseg assertion failed");

// Checks a property on every clock edge, reset included.
`define TMSEG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tmseg assertion failed");

`endif

@@ src/tmseg_pkg.sv @@
`default_nettype none
package tmseg_pkg;

    localparam int SPEED_W = 40;
    localparam int DIR_W   = 63;
    localparam int RATIO_W = 21;
    localparam int MAG_W   = 64;

    localparam int SHIFT_W = 16;
    localparam int SHIFT_D = 24;
    localparam int SHIFT_R = 20;

    localparam logic [MAG_W-1:0] MAG_CAP = 64'h4000_0000_0000_0000;

    localparam logic [1:0] MUL_W = 2'd0;
    localparam logic [1:0] MUL_D = 2'd1;
    localparam logic [1:0] MUL_R = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_mul_req;

    function automatic logic [MAG_W-1:0] abs64(input logic signed [MAG_W-1:0] x);
        return x[MAG_W-1] ? MAG_W'(-x) : MAG_W'(x);
    endfunction

endpackage
`default_nettype wire

@@ src/tmseg_if.sv @@
`default_nettype none
interface tmseg_cfg_if #(parameter int TIME_WIDTH = 48);
    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tmseg_move_if import tmseg_pkg::*; #(
    parameter int TIME_WIDTH = 48,
    parameter int POS_WIDTH  = 44
);
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [TIME_WIDTH-1:0]       start_time;
    logic [TIME_WIDTH-1:0]       accel_time;
    logic [TIME_WIDTH-1:0]       cruise_time;
    logic [TIME_WIDTH-1:0]       decel_time;
    logic signed [POS_WIDTH-1:0] start_x;
    logic signed [POS_WIDTH-1:0] start_y;
    logic signed [POS_WIDTH-1:0] start_z;
    logic [DIR_W-1:0]            direction;
    logic signed [SPEED_W-1:0]   start_speed;
    logic signed [SPEED_W-1:0]   cruise_speed;
    logic signed [SPEED_W-1:0]   acceleration;
    modport source (output valid, output action, output start_time, output accel_time,
                    output cruise_time, output decel_time, output start_x, output start_y,
                    output start_z, output direction, output start_speed,
                    output cruise_speed, output acceleration, input ready);
    modport sink (input valid, input action, input start_time, input accel_time,
                  input cruise_time, input decel_time, input start_x, input start_y,
                  input start_z, input direction, input start_speed,
                  input cruise_speed, input acceleration, output ready);
endinterface

interface tmseg_seg_if import tmseg_pkg::*; #(
    parameter int TIME_WIDTH = 48,
    parameter int POS_WIDTH  = 44
);
    logic                        valid;
    logic                        ready;
    logic [TIME_WIDTH-1:0]       seg_start_time;
    logic [TIME_WIDTH-1:0]       seg_duration;
    logic signed [SPEED_W-1:0]   seg_start_speed;
    logic signed [SPEED_W-1:0]   seg_half_accel;
    logic signed [POS_WIDTH-1:0] seg_x;
    logic signed [POS_WIDTH-1:0] seg_y;
    logic signed [POS_WIDTH-1:0] seg_z;
    logic [DIR_W-1:0]            seg_direction;
    logic                        last;
    modport source (output valid, output seg_start_time, output seg_duration,
                    output seg_start_speed, output seg_half_accel, output seg_x,
                    output seg_y, output seg_z, output seg_direction, output last,
                    input ready);
    modport sink (input valid, input seg_start_time, input seg_duration,
                  input seg_start_speed, input seg_half_accel, input seg_x,
                  input seg_y, input seg_z, input seg_direction, input last,
                  output ready);
endinterface
`default_nettype wire

@@ src/tmseg_mul.sv @@
`default_nettype none
module tmseg_mul import tmseg_pkg::*; #(
    parameter int TIME_WIDTH = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mul_req         i_req,
    input  logic [MAG_W-1:0] i_a,
    input  logic [MAG_W-1:0] i_b,
    output logic             o_done,
    output logic [MAG_W-1:0] o_mag
);

    localparam int K_W = MAG_W - TIME_WIDTH + SHIFT_W;
    localparam int K_D = MAG_W - TIME_WIDTH + SHIFT_D;
    localparam int K_R = MAG_W - RATIO_W + SHIFT_R;

    logic                 r_busy;
    logic                 r_done;
    logic [5:0]           r_cnt;
    logic [1:0]           r_op;
    logic [MAG_W-1:0]     r_a;
    logic [MAG_W-1:0]     r_b;
    logic [2*MAG_W-1:0]   r_acc;
    logic [MAG_W:0]       w_sum;
    logic [2*MAG_W-1:0]   w_full;

    assign w_sum = {1'b0, r_acc[2*MAG_W-1:MAG_W]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_comb begin
        unique case (r_op)
            MUL_W:   w_full = r_acc >> K_W;
            MUL_D:   w_full = r_acc >> K_D;
            default: w_full = r_acc >> K_R;
        endcase
    end

    assign o_mag  = (|w_full[2*MAG_W-1:MAG_W] || (w_full[MAG_W-1:0] > MAG_CAP))
                    ? MAG_CAP : w_full[MAG_W-1:0];
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= (i_req.op == MUL_R) ? 6'(RATIO_W - 1) : 6'(TIME_WIDTH - 1);
            end else if (r_busy) begin
                r_acc <= {w_sum, r_acc[MAG_W-1:1]};
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ src/trapezoid_move_segmenter_top.sv @@
// Splits each appended trapezoidal move into up to four timed segments: a zero-speed
// gap filler when the move starts after the last queued segment ends, then one segment
// per nonzero accel, cruise and decel phase, each with its start position advanced by
// direction times (v + a/2*t)*t with saturation. A retire request with a time at or past
// the last segment end empties the queue and produces no segment. The configuration
// port is always ready. Each present phase waits for a full output register to drain
// before its segment, and a gap filler when one is needed, is emitted; its position
// update then runs on the one shared bit-serial multiplier, which retires one multiplier
// bit per cycle for the speed, distance and three axis products in turn. One move is
// worked at a time; the next request is taken while the final segment still waits on
// the output.
`default_nettype none
module trapezoid_move_segmenter_top import tmseg_pkg::*; #(
    parameter int TIME_WIDTH = 48,
    parameter int POS_WIDTH  = 44
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tmseg_cfg_if.sink    i_cfg,
    tmseg_move_if.sink   i_move,
    tmseg_seg_if.source  o_seg
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NEXT = 4'd1;
    localparam logic [3:0] S_GAP  = 4'd2;
    localparam logic [3:0] S_SEG  = 4'd3;
    localparam logic [3:0] S_MW   = 4'd4;
    localparam logic [3:0] S_DS   = 4'd5;
    localparam logic [3:0] S_MD   = 4'd6;
    localparam logic [3:0] S_RS   = 4'd7;
    localparam logic [3:0] S_MR   = 4'd8;

    localparam logic [TIME_WIDTH-1:0] LIMIT_RESET = TIME_WIDTH'(64'd16777216);
    localparam logic signed [65:0] PMAX = (66'sd1 <<< (POS_WIDTH - 1)) - 66'sd1;
    localparam logic signed [65:0] PMIN = -PMAX - 66'sd1;

    logic [3:0]                  r_state, n_state;
    logic [TIME_WIDTH-1:0]       r_limit, r_prev_start, r_prev_end, r_t;
    logic [TIME_WIDTH-1:0]       r_phase [4];
    logic signed [POS_WIDTH-1:0] r_pos [3];
    logic [DIR_W-1:0]            r_dir;
    logic signed [SPEED_W-1:0]   r_ss, r_cs, r_h;
    logic [1:0]                  r_idx, r_axis;
    logic signed [MAG_W-1:0]     r_s, r_d;

    logic                        r_o_valid, r_o_last;
    logic [TIME_WIDTH-1:0]       r_o_t0, r_o_dur;
    logic signed [SPEED_W-1:0]   r_o_v, r_o_ha;
    logic signed [POS_WIDTH-1:0] r_o_p [3];
    logic [DIR_W-1:0]            r_o_dir;

    logic                        w_accept, w_out_free, w_emit_gap, w_emit_seg;
    logic [TIME_WIDTH-1:0]       w_dur, w_gap_fs, w_gap_dur, w_seg_end;
    logic [TIME_WIDTH:0]         w_end_sum;
    logic signed [SPEED_W-1:0]   w_v, w_ha;
    logic                        w_last, w_gap_need;
    logic signed [RATIO_W-1:0]   w_ratio;
    logic signed [POS_WIDTH-1:0] w_pos_sel, w_pos_new;
    logic signed [MAG_W-1:0]     w_mag_s, w_delta;
    logic signed [65:0]          w_pos_sum;
    t_mul_req                    w_req;
    logic [MAG_W-1:0]            w_mul_a, w_mul_b, w_mag;
    logic                        w_mul_done;

    assign w_accept   = i_move.valid && i_move.ready;
    assign w_out_free = !r_o_valid || o_seg.ready;
    assign w_emit_gap = (r_state == S_GAP) && w_out_free;
    assign w_emit_seg = (r_state == S_SEG) && w_out_free;

    assign w_dur     = r_phase[r_idx];
    assign w_v       = (r_idx == 2'd0) ? r_ss : r_cs;
    assign w_end_sum = {1'b0, r_t} + {1'b0, w_dur};
    assign w_seg_end = w_end_sum[TIME_WIDTH] ? '1 : w_end_sum[TIME_WIDTH-1:0];

    always_comb begin
        unique case (r_idx)
            2'd0: begin
                w_ha   = r_h;
                w_last = (r_phase[1] == '0) && (r_phase[2] == '0);
            end
            2'd1: begin
                w_ha   = '0;
                w_last = (r_phase[2] == '0);
            end
            default: begin
                w_ha   = -r_h;
                w_last = 1'b1;
            end
        endcase
    end

    assign w_gap_need = r_prev_end < r_t;
    assign w_gap_fs   = ((r_prev_start == '0) && (r_t > r_limit)) ? (r_t - r_limit)
                                                                  : r_prev_end;
    assign w_gap_dur  = r_t - w_gap_fs;

    always_comb begin
        unique case (r_axis)
            2'd0: begin
                w_ratio   = r_dir[RATIO_W-1:0];
                w_pos_sel = r_pos[0];
            end
            2'd1: begin
                w_ratio   = r_dir[2*RATIO_W-1:RATIO_W];
                w_pos_sel = r_pos[1];
            end
            default: begin
                w_ratio   = r_dir[3*RATIO_W-1:2*RATIO_W];
                w_pos_sel = r_pos[2];
            end
        endcase
    end

    assign w_mag_s   = w_mag;
    assign w_delta   = (w_ratio[RATIO_W-1] ^ r_d[MAG_W-1]) ? -w_mag_s : w_mag_s;
    assign w_pos_sum = 66'(w_pos_sel) + 66'(w_delta);
    assign w_pos_new = (w_pos_sum > PMAX) ? PMAX[POS_WIDTH-1:0] :
                       (w_pos_sum < PMIN) ? PMIN[POS_WIDTH-1:0] :
                       w_pos_sum[POS_WIDTH-1:0];

    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = MUL_W;
        w_mul_a     = abs64(MAG_W'(w_ha));
        w_mul_b     = MAG_W'(w_dur);
        unique case (r_state)
            S_SEG: w_req.start = w_out_free;
            S_DS: begin
                w_req.start = 1'b1;
                w_req.op    = MUL_D;
                w_mul_a     = abs64(r_s);
            end
            S_RS: begin
                w_req.start = 1'b1;
                w_req.op    = MUL_R;
                w_mul_a     = abs64(r_d);
                w_mul_b     = MAG_W'(abs64(MAG_W'(w_ratio)));
            end
            default: w_req.start = 1'b0;
        endcase
    end

    tmseg_mul #(.TIME_WIDTH(TIME_WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_mag   (w_mag)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept && !i_move.action) n_state = S_NEXT;
            S_NEXT: begin
                if (w_dur == '0) begin
                    if (r_idx == 2'd3) n_state = S_IDLE;
                end else begin
                    n_state = w_gap_need ? S_GAP : S_SEG;
                end
            end
            S_GAP: if (w_out_free) n_state = S_SEG;
            S_SEG: if (w_out_free) n_state = S_MW;
            S_MW:  if (w_mul_done) n_state = S_DS;
            S_DS:  n_state = S_MD;
            S_MD:  if (w_mul_done) n_state = S_RS;
            S_RS:  n_state = S_MR;
            S_MR:  if (w_mul_done) n_state = (r_axis == 2'd2) ? S_NEXT : S_RS;
            default: n_state = S_IDLE;
        endcase
    end

    assign i_move.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_limit      <= LIMIT_RESET;
            r_prev_start <= '0;
            r_prev_end   <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) r_limit <= i_cfg.data;

            if (w_accept) begin
                if (i_move.action) begin
                    if (i_move.start_time >= r_prev_end) begin
                        r_prev_start <= '0;
                        r_prev_end   <= '0;
                    end
                end else begin
                    r_t        <= i_move.start_time;
                    r_phase[0] <= i_move.accel_time;
                    r_phase[1] <= i_move.cruise_time;
                    r_phase[2] <= i_move.decel_time;
                    r_phase[3] <= '0;
                    r_pos[0]   <= i_move.start_x;
                    r_pos[1]   <= i_move.start_y;
                    r_pos[2]   <= i_move.start_z;
                    r_dir      <= i_move.direction;
                    r_ss       <= i_move.start_speed;
                    r_cs       <= i_move.cruise_speed;
                    r_h        <= i_move.acceleration >>> 1;
                    r_idx      <= 2'd0;
                end
            end

            if ((r_state == S_NEXT) && (w_dur == '0) && (r_idx != 2'd3)) begin
                r_idx <= r_idx + 2'd1;
            end

            if (w_emit_gap) begin
                r_o_valid <= 1'b1;
                r_o_t0    <= w_gap_fs;
                r_o_dur   <= w_gap_dur;
                r_o_v     <= '0;
                r_o_ha    <= '0;
                r_o_p     <= r_pos;
                r_o_dir   <= '0;
                r_o_last  <= 1'b0;
            end else if (w_emit_seg) begin
                r_o_valid    <= 1'b1;
                r_o_t0       <= r_t;
                r_o_dur      <= w_dur;
                r_o_v        <= w_v;
                r_o_ha       <= w_ha;
                r_o_p        <= r_pos;
                r_o_dir      <= r_dir;
                r_o_last     <= w_last;
                r_prev_start <= r_t;
                r_prev_end   <= w_seg_end;
                r_t          <= w_seg_end;
            end else if (o_seg.ready) begin
                r_o_valid <= 1'b0;
            end

            if ((r_state == S_MW) && w_mul_done) begin
                r_s <= MAG_W'(w_v) + (w_ha[SPEED_W-1] ? -w_mag_s : w_mag_s);
            end
            if ((r_state == S_MD) && w_mul_done) begin
                r_d    <= r_s[MAG_W-1] ? -w_mag_s : w_mag_s;
                r_axis <= 2'd0;
            end
            if ((r_state == S_MR) && w_mul_done) begin
                unique case (r_axis)
                    2'd0:    r_pos[0] <= w_pos_new;
                    2'd1:    r_pos[1] <= w_pos_new;
                    default: r_pos[2] <= w_pos_new;
                endcase
                if (r_axis == 2'd2) begin
                    r_idx <= r_idx + 2'd1;
                end else begin
                    r_axis <= r_axis + 2'd1;
                end
            end
        end
    end

    assign o_seg.valid           = r_o_valid;
    assign o_seg.seg_start_time  = r_o_t0;
    assign o_seg.seg_duration    = r_o_dur;
    assign o_seg.seg_start_speed = r_o_v;
    assign o_seg.seg_half_accel  = r_o_ha;
    assign o_seg.seg_x           = r_o_p[0];
    assign o_seg.seg_y           = r_o_p[1];
    assign o_seg.seg_z           = r_o_p[2];
    assign o_seg.seg_direction   = r_o_dir;
    assign o_seg.last            = r_o_last;

endmodule
`default_nettype wire

@@ src/tmseg_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module tmseg_checker #(
    parameter int POS_WIDTH = 44
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_in_action,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [POS_WIDTH-1:0] i_out_x
);

    `TMSEG_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid)
    `TMSEG_ASSERT(a_retire_silent, i_clk, i_rst_n,
        (i_in_valid && i_in_ready && i_in_action && !i_out_valid) |=> !i_out_valid)
    `TMSEG_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid)
    `TMSEG_ASSERT(a_out_stable, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=> $stable(i_out_x))

endmodule

bind trapezoid_move_segmenter_top tmseg_checker #(.POS_WIDTH(POS_WIDTH)) u_tmseg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_move.valid),
    .i_in_ready  (i_move.ready),
    .i_in_action (i_move.action),
    .i_out_valid (o_seg.valid),
    .i_out_ready (o_seg.ready),
    .i_out_x     (o_seg.seg_x)
);
`default_nettype wire

@@ verif/trapezoid_move_segmenter_top_test.sv @@
`timescale 1ns / 1ps
module trapezoid_move_segmenter_top_test;
    import tmseg_pkg::*;

    localparam int TW = 48;
    localparam int PW = 44;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_RETIRE = 1'b1;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [TW-1:0]      t0;
        logic [TW-1:0]      dur;
        logic [SPEED_W-1:0] v;
        logic [SPEED_W-1:0] ha;
        logic [PW-1:0]      x;
        logic [PW-1:0]      y;
        logic [PW-1:0]      z;
        logic [DIR_W-1:0]   dir;
        logic               last;
    } t_seg;

    typedef struct {
        logic                     action;
        logic [TW-1:0]            t;
        logic [TW-1:0]            ph [3];
        logic signed [PW-1:0]     p [3];
        logic [DIR_W-1:0]         dir;
        logic signed [SPEED_W-1:0] v0;
        logic signed [SPEED_W-1:0] vc;
        logic signed [SPEED_W-1:0] acc;
    } t_move;

    function automatic logic [63:0] mag_mul(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        if (p > {64'd0, MAG_CAP}) return MAG_CAP;
        return p[63:0];
    endfunction

    function automatic longint smul_u(longint x, logic [63:0] y, int sh);
        logic [63:0] mx;
        longint m;
        mx = x < 0 ? 64'(-x) : 64'(x);
        m = longint'(mag_mul(mx, y, sh));
        return x < 0 ? -m : m;
    endfunction

    function automatic longint pos_add(longint b, longint d);
        longint pmax, pmin, r;
        pmax = (longint'(1) <<< (PW - 1)) - 1;
        pmin = -pmax - 1;
        r = b + d;
        if (r > pmax) return pmax;
        if (r < pmin) return pmin;
        return r;
    endfunction

    function automatic logic [TW-1:0] tadd(logic [TW-1:0] a, logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? TMAX : s[TW-1:0];
    endfunction

    class segment_scoreboard;
        t_seg pending[$];
        logic [TW-1:0] gap_limit = TW'(64'd16777216);
        logic [TW-1:0] last_start = '0;
        logic [TW-1:0] last_end = '0;
        int errors = 0;

        function void note_move(t_move m);
            logic [TW-1:0] t, fs;
            longint pos[3], a, h, w, d, r;
            longint spd[3], hac[3];
            t_seg s;
            int n0;
            if (m.action == ACT_RETIRE) begin
                if (m.t >= last_end) begin
                    last_start = '0;
                    last_end = '0;
                end
                return;
            end
            t = m.t;
            for (int i = 0; i < 3; i++) pos[i] = m.p[i];
            a = m.acc;
            h = a >= 0 ? a / 2 : -((-a + 1) / 2);
            spd[0] = m.v0; spd[1] = m.vc; spd[2] = m.vc;
            hac[0] = h; hac[1] = 0; hac[2] = -h;
            n0 = pending.size();
            for (int i = 0; i < 3; i++) begin
                if (m.ph[i] == 0) continue;
                if (last_end < t) begin
                    fs = (last_start == 0 && t > gap_limit) ? t - gap_limit : last_end;
                    s = '{t0: fs, dur: t - fs, v: '0, ha: '0, x: pos[0][PW-1:0],
                          y: pos[1][PW-1:0], z: pos[2][PW-1:0], dir: '0, last: 1'b0};
                    pending.push_back(s);
                end
                s = '{t0: t, dur: m.ph[i], v: spd[i][SPEED_W-1:0], ha: hac[i][SPEED_W-1:0],
                      x: pos[0][PW-1:0], y: pos[1][PW-1:0], z: pos[2][PW-1:0],
                      dir: m.dir, last: 1'b0};
                pending.push_back(s);
                last_start = t;
                last_end = tadd(t, m.ph[i]);
                w = smul_u(hac[i], 64'(m.ph[i]), SHIFT_W);
                d = smul_u(spd[i] + w, 64'(m.ph[i]), SHIFT_D);
                for (int k = 0; k < 3; k++) begin
                    r = longint'($signed(m.dir[k*RATIO_W +: RATIO_W]));
                    if (d < 0) r = -smul_u(r, 64'(-d), SHIFT_R);
                    else r = smul_u(r, 64'(d), SHIFT_R);
                    pos[k] = pos_add(pos[k], r);
                end
                t = tadd(t, m.ph[i]);
            end
            if (pending.size() > n0) pending[$].last = 1'b1;
        endfunction

        function void check_segment(t_seg got);
            t_seg e;
            if (pending.size() == 0) begin
                $error("unexpected segment t0=%0h", got.t0);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.t0 !== e.t0) begin
                $error("seg_start_time exp %0h got %0h", e.t0, got.t0); errors++;
            end
            if (got.dur !== e.dur) begin
                $error("seg_duration exp %0h got %0h", e.dur, got.dur); errors++;
            end
            if (got.v !== e.v) begin
                $error("seg_start_speed exp %0h got %0h", e.v, got.v); errors++;
            end
            if (got.ha !== e.ha) begin
                $error("seg_half_accel exp %0h got %0h", e.ha, got.ha); errors++;
            end
            if (got.x !== e.x) begin
                $error("seg_x exp %0h got %0h", e.x, got.x); errors++;
            end
            if (got.y !== e.y) begin
                $error("seg_y exp %0h got %0h", e.y, got.y); errors++;
            end
            if (got.z !== e.z) begin
                $error("seg_z exp %0h got %0h", e.z, got.z); errors++;
            end
            if (got.dir !== e.dir) begin
                $error("seg_direction exp %0h got %0h", e.dir, got.dir); errors++;
            end
            if (got.last !== e.last) begin
                $error("last exp %0h got %0h", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    tmseg_cfg_if #(.TIME_WIDTH(TW)) cfg_bus();
    tmseg_move_if #(.TIME_WIDTH(TW), .POS_WIDTH(PW)) move_bus();
    tmseg_seg_if #(.TIME_WIDTH(TW), .POS_WIDTH(PW)) seg_bus();

    trapezoid_move_segmenter_top #(.TIME_WIDTH(TW), .POS_WIDTH(PW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg_bus), .i_move(move_bus), .o_seg(seg_bus)
    );

    segment_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    bit stim_done = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        seg_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            seg_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_seg got;
        if (i_rst_n && seg_bus.valid && seg_bus.ready) begin
            got = '{t0: seg_bus.seg_start_time, dur: seg_bus.seg_duration,
                    v: seg_bus.seg_start_speed, ha: seg_bus.seg_half_accel,
                    x: seg_bus.seg_x, y: seg_bus.seg_y, z: seg_bus.seg_z,
                    dir: seg_bus.seg_direction, last: seg_bus.last};
            board.check_segment(got);
        end
        if ((seg_bus.valid && seg_bus.ready) || (move_bus.valid && move_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_gap_limit(logic [TW-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        board.gap_limit = value;
    endtask

    task automatic send_move(t_move m);
        while ($urandom_range(99) < send_idle_pct) begin
            move_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        move_bus.valid <= 1'b1;
        move_bus.action <= m.action;
        move_bus.start_time <= m.t;
        move_bus.accel_time <= m.ph[0];
        move_bus.cruise_time <= m.ph[1];
        move_bus.decel_time <= m.ph[2];
        move_bus.start_x <= m.p[0];
        move_bus.start_y <= m.p[1];
        move_bus.start_z <= m.p[2];
        move_bus.direction <= m.dir;
        move_bus.start_speed <= m.v0;
        move_bus.cruise_speed <= m.vc;
        move_bus.acceleration <= m.acc;
        do @(posedge i_clk); while (!move_bus.ready);
        board.note_move(m);
    endtask

    task automatic drain();
        move_bus.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TW-1:0] rand_dur();
        case ($urandom_range(9))
            0: return '0;
            1: return TW'(rand64());
            2: return TW'($urandom_range(15));
            default: return TW'({$urandom_range(3), $urandom});
        endcase
    endfunction

    function automatic t_move random_move(logic [TW-1:0] t);
        t_move m;
        m.action = ($urandom_range(9) == 0) ? ACT_RETIRE : ACT_APPEND;
        m.t = ($urandom_range(7) == 0) ? TW'(rand64()) : t;
        for (int i = 0; i < 3; i++) begin
            m.ph[i] = rand_dur();
            m.p[i] = ($urandom_range(3) == 0) ? PW'(rand64()) : PW'($signed($urandom));
        end
        m.dir = DIR_W'(rand64());
        m.v0 = SPEED_W'(rand64());
        m.vc = SPEED_W'(rand64());
        m.acc = SPEED_W'(rand64());
        return m;
    endfunction

    function automatic t_move plain_move(logic act, logic [TW-1:0] t, logic [TW-1:0] d);
        t_move m;
        m.action = act;
        m.t = t;
        for (int i = 0; i < 3; i++) begin
            m.ph[i] = d;
            m.p[i] = '0;
        end
        m.dir = {21'h40000, 21'h0fffff, 21'h100000};
        m.v0 = SPEED_W'(64'h100_0000);
        m.vc = SPEED_W'(64'h400_0000);
        m.acc = SPEED_W'(64'h3_0001);
        return m;
    endfunction

    initial begin
        t_move m;
        logic [TW-1:0] clock_t;
        cfg_bus.valid = 1'b0;
        cfg_bus.data = '0;
        move_bus.valid = 1'b0;
        move_bus.action = ACT_APPEND;
        move_bus.start_time = '0;
        move_bus.accel_time = '0;
        move_bus.cruise_time = '0;
        move_bus.decel_time = '0;
        move_bus.start_x = '0;
        move_bus.start_y = '0;
        move_bus.start_z = '0;
        move_bus.direction = '0;
        move_bus.start_speed = '0;
        move_bus.cruise_speed = '0;
        move_bus.acceleration = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: gap limit, overlap, empty move, retire, extremes.
        send_move(plain_move(ACT_APPEND, TW'(64'h300_0000), TW'(64'h10_0000)));
        send_move(plain_move(ACT_APPEND, TW'(64'h300_0000), TW'(64'h1_0000)));
        send_move(plain_move(ACT_APPEND, TW'(64'h800_0000), '0));
        send_move(plain_move(ACT_RETIRE, TW'(64'h100_0000), '0));
        send_move(plain_move(ACT_APPEND, TW'(64'h900_0000), TW'(64'h20_0000)));
        send_move(plain_move(ACT_RETIRE, TMAX, '0));
        send_move(plain_move(ACT_APPEND, '0, TW'(64'h5)));
        send_move(plain_move(ACT_APPEND, TW'(64'h100), TW'(64'h5)));
        send_move(plain_move(ACT_RETIRE, TMAX, '0));
        m = plain_move(ACT_APPEND, TMAX - 2, TMAX);
        m.p[0] = {1'b0, {(PW-1){1'b1}}};
        m.p[1] = {1'b1, {(PW-1){1'b0}}};
        m.p[2] = '1;
        m.dir = {1'b0, {(DIR_W-1){1'b1}}} ^ 63'h1;
        m.v0 = {1'b0, {(SPEED_W-1){1'b1}}};
        m.vc = {1'b1, {(SPEED_W-1){1'b0}}};
        m.acc = {1'b1, {(SPEED_W-1){1'b0}}};
        send_move(m);
        m.dir = '1;
        m.acc = {1'b0, {(SPEED_W-1){1'b1}}};
        m.vc = '1;
        send_move(m);
        send_move(plain_move(ACT_RETIRE, '0, '0));
        send_move(plain_move(ACT_RETIRE, TMAX, '0));
        drain();
        write_gap_limit('0);
        send_move(plain_move(ACT_APPEND, TW'(64'h50_0000), TW'(64'h3_0000)));
        send_move(plain_move(ACT_RETIRE, TMAX, '0));
        drain();
        write_gap_limit(TMAX);
        send_move(plain_move(ACT_APPEND, TW'(64'h50_0000), TW'(64'h3_0000)));
        send_move(plain_move(ACT_RETIRE, TMAX, '0));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 57 : 16) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 57 : 16) : 0;
            write_gap_limit(phase == 2 ? TW'(rand64()) : TW'($urandom_range(32'h200_0000)));
            clock_t = TW'($urandom_range(32'h400_0000));
            for (int k = 0; k < 21; k++) begin
                m = random_move(clock_t);
                send_move(m);
                if (m.action == ACT_APPEND)
                    clock_t = tadd(tadd(tadd(tadd(m.t, m.ph[0]), m.ph[1]), m.ph[2]),
                                   TW'($urandom_range(3) == 0 ? 0 : $urandom_range(32'hff_ffff)));
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+src
src/tmseg_pkg.sv
src/tmseg_if.sv
src/tmseg_mul.sv
src/trapezoid_move_segmenter_top.sv
src/tmseg_checker.sv
verif/trapezoid_move_segmenter_top_test.sv
